[hdl/ntt_tw_pkg.sv]
// Package for the NTT twiddle table generator.
// Holds register indexes, field widths, sequencer states and divider request types.
// No dependencies.
`default_nettype none
package ntt_tw_pkg;

  localparam int unsigned DATA_W   = 16;
  localparam int unsigned SLOT_W   = 9;
  localparam int unsigned SHIFT_W  = 5;
  localparam int unsigned NUM_W    = 48;
  localparam int unsigned DVD_W    = 32;
  localparam int unsigned STEP_W   = 6;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned OUT_W    = 48;
  localparam int unsigned IN_W     = 8;

  localparam logic [DATA_W-1:0] FACTOR_MAX = 16'hFFFF;

  localparam logic [STEP_W-1:0] FACTOR_STEPS = 6'd16;
  localparam logic [STEP_W-1:0] MOD_STEPS    = 6'd32;

  localparam logic [IDX_W-1:0] REG_OMEGA   = 2'd0;
  localparam logic [IDX_W-1:0] REG_MODULUS = 2'd1;
  localparam logic [IDX_W-1:0] REG_SHIFT   = 2'd2;

  localparam logic [DATA_W-1:0]  OMEGA_RST   = 16'd1;
  localparam logic [DATA_W-1:0]  MODULUS_RST = 16'd65521;
  localparam logic [SHIFT_W-1:0] SHIFT_RST   = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CHK,
    ST_FDIV,
    ST_MOD,
    ST_MDIV,
    ST_OUT
  } st_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] divisor;
    logic [DATA_W-1:0] rem_init;
    logic [DVD_W-1:0]  dvd_init;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

[hdl/ntt_tw_div.sv]
// Radix-2 restoring divider shared by the factor and the power reduction.
// One quotient bit per cycle; remainder start value must be below the divisor.
// Depends on ntt_tw_pkg.
`default_nettype none
module ntt_tw_div (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ntt_tw_pkg::div_req_t req,
  output ntt_tw_pkg::div_rsp_t      rsp
);
  import ntt_tw_pkg::*;

  logic [DATA_W-1:0] rem_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DATA_W-1:0] dsr_r;
  logic [STEP_W-1:0] cnt_r;
  logic              done_r;

  logic [DATA_W:0]   trial;
  logic              ge;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= req.steps;
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - STEP_W'(1);
        done_r <= (cnt_r == STEP_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem_init;
      dvd_r <= req.dvd_init;
      dsr_r <= req.divisor;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? DATA_W'(trial - {1'b0, dsr_r}) : trial[DATA_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = dvd_r[DATA_W-1:0];
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

[hdl/ntt_twiddle_table_generator_top.sv]
// NTT twiddle table generator, bit-reversed order, with rounded Barrett factor.
// Sequencer, power state and output register; divisions in ntt_tw_div.
// Depends on ntt_tw_pkg and ntt_tw_div.
//
//  channel  dir  payload
//  in_      in   tdata[0] restart
//  out_     out  tdata: slot_index, twiddle, barrett_factor, overflow; tlast: last_entry
//  cfg_     in   index 0 omega, 1 modulus, 2 barrett_shift
//
// One request runs from accept back to ready through prep, check, the factor divide
// (16 steps), a state to start the reduction, the reduction (32 steps) and the output
// load, all on the one shared divider. No factor divide on zero modulus or a saturated
// factor; no reduction on the last entry or zero modulus.
// in_tready is high only while idle; a full output register holds the sequencer.
// rst_n is synchronous: power 1, step 0, registers at reset values.
`default_nettype none
module ntt_twiddle_table_generator_top #(
  parameter int unsigned TABLE_SIZE = 512
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [ntt_tw_pkg::IN_W-1:0]   in_tdata,   // [0] restart
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [8:0] slot_index, [24:9] twiddle, [40:25] barrett_factor, [41] overflow
  output logic [ntt_tw_pkg::OUT_W-1:0]       out_tdata,
  output logic                               out_tlast,  // last_entry
  input  wire logic                          cfg_we,
  input  wire logic [ntt_tw_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [ntt_tw_pkg::DATA_W-1:0] cfg_wdata
);
  import ntt_tw_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_SIZE);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_SIZE - 1);

  logic [DATA_W-1:0]  omega_r;
  logic [DATA_W-1:0]  mod_r;
  logic [SHIFT_W-1:0] shift_r;

  st_t                state_r, state_nxt;
  logic [DATA_W-1:0]  power_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [NUM_W-1:0]   num_r;
  logic [DVD_W-1:0]   prod_r;
  logic [DATA_W-1:0]  factor_r;
  logic               ovf_r;
  logic [DATA_W-1:0]  npow_r;

  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;
  logic               out_last_r;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               accept;
  logic               is_last;
  logic               mod_zero;
  logic               sat;
  logic               load_out;
  logic [NUM_W-1:0]   wide_shift;
  logic [CNT_W-1:0]   rev;
  logic [SLOT_W+CNT_W-1:0] rev_ext;
  logic [SLOT_W-1:0]  slot;

  ntt_tw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign accept     = in_tvalid && in_tready;
  assign is_last    = (cnt_r == CNT_LAST);
  assign mod_zero   = (mod_r == '0);
  assign sat        = mod_zero || (num_r >= {16'd0, mod_r, 16'd0});
  assign wide_shift = {32'd0, power_r} << shift_r;
  assign load_out   = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    for (int i = 0; i < CNT_W; i++) begin
      rev[i] = cnt_r[CNT_W-1-i];
    end
  end
  assign rev_ext = {{SLOT_W{1'b0}}, rev};
  assign slot    = rev_ext[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      omega_r <= OMEGA_RST;
      mod_r   <= MODULUS_RST;
      shift_r <= SHIFT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OMEGA:   omega_r <= cfg_wdata;
        REG_MODULUS: mod_r   <= cfg_wdata;
        REG_SHIFT:   shift_r <= cfg_wdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    in_tready        = 1'b0;
    div_req.start    = 1'b0;
    div_req.divisor  = mod_r;
    div_req.rem_init = num_r[31:16];
    div_req.dvd_init = {num_r[15:0], 16'd0};
    div_req.steps    = FACTOR_STEPS;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = ST_PREP;
      end
      ST_PREP: state_nxt = ST_CHK;
      ST_CHK: begin
        if (sat) begin
          state_nxt = ST_MOD;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_FDIV;
        end
      end
      ST_FDIV: if (div_rsp.done) state_nxt = ST_MOD;
      ST_MOD: begin
        if (is_last || mod_zero) begin
          state_nxt = ST_OUT;
        end else begin
          div_req.start    = 1'b1;
          div_req.rem_init = '0;
          div_req.dvd_init = prod_r;
          div_req.steps    = MOD_STEPS;
          state_nxt        = ST_MDIV;
        end
      end
      ST_MDIV: if (div_rsp.done) state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_r <= 16'd1;
      cnt_r   <= '0;
    end else if (accept && in_tdata[0]) begin
      power_r <= 16'd1;
      cnt_r   <= '0;
    end else if (load_out) begin
      power_r <= is_last ? 16'd1 : npow_r;
      cnt_r   <= is_last ? '0 : cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_PREP: begin
        num_r  <= wide_shift + {33'd0, mod_r[DATA_W-1:1]};
        prod_r <= power_r * omega_r;
      end
      ST_CHK: begin
        if (sat) begin
          factor_r <= FACTOR_MAX;
          ovf_r    <= 1'b1;
        end
      end
      ST_FDIV: begin
        if (div_rsp.done) begin
          factor_r <= div_rsp.quo;
          ovf_r    <= (div_rsp.quo == FACTOR_MAX);
        end
      end
      ST_MOD: npow_r <= prod_r[DATA_W-1:0];
      ST_MDIV: if (div_rsp.done) npow_r <= div_rsp.rem;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {6'd0, ovf_r, factor_r, power_r, slot};
      out_last_r <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_FDIV) || (state_r == ST_MDIV))
    else $error("divider finished outside a divide state");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_LAST)
    else $error("step counter beyond table end");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("input taken while a request is in progress");

  a_rem_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (div_rsp.done && state_r == ST_MDIV) |-> (div_rsp.rem < mod_r))
    else $error("reduced power not below modulus");

endmodule
`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for the NTT twiddle table generator: streams restart/advance requests and
// predicts each table entry (slot, power, rounded factor, flags) to check the result stream.
// Depends on ntt_tw_pkg and ntt_twiddle_table_generator_top.
module tb_top;
  import ntt_tw_pkg::*;

  localparam int unsigned TBL_SIZE    = 512;
  localparam int unsigned MAX_REPORTS = 20;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] twiddle;
    logic [DATA_W-1:0] factor;
    logic              ovf;
    logic              last;
  } entry_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata   = '0;    // [0] restart
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // [8:0] slot_index, [24:9] twiddle, [40:25] barrett_factor, [41] overflow
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tlast;          // last_entry
  logic              cfg_we     = 1'b0;
  logic [IDX_W-1:0]  cfg_index  = '0;
  logic [DATA_W-1:0] cfg_wdata  = '0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  logic [DATA_W-1:0]  m_omega   = OMEGA_RST;
  logic [DATA_W-1:0]  m_modulus = MODULUS_RST;
  logic [SHIFT_W-1:0] m_shift   = SHIFT_RST;
  logic [DATA_W-1:0]  m_power   = 16'd1;
  logic [SLOT_W-1:0]  m_step    = '0;

  entry_t pending_entries[$];

  int unsigned err_count  = 0;
  int unsigned n_requests = 0;
  int unsigned n_results  = 0;
  int unsigned n_ovf      = 0;
  int unsigned n_wraps    = 0;
  int unsigned n_settings = 0;

  ntt_twiddle_table_generator_top #(
    .TABLE_SIZE(TBL_SIZE)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  task automatic predict_entry(input logic restart);
    entry_t      e;
    logic [63:0] num;
    logic [63:0] quo;
    logic [31:0] prod;
    if (restart) begin
      m_step  = '0;
      m_power = 16'd1;
    end
    e.twiddle = m_power;
    for (int b = 0; b < SLOT_W; b++) e.slot[SLOT_W-1-b] = m_step[b];
    if (m_modulus == '0) begin
      e.factor = FACTOR_MAX;
      e.ovf    = 1'b1;
    end else begin
      num = (64'(m_power) << m_shift) + 64'(m_modulus >> 1);
      quo = num / 64'(m_modulus);
      if (quo >= 64'(FACTOR_MAX)) begin
        e.factor = FACTOR_MAX;
        e.ovf    = 1'b1;
      end else begin
        e.factor = quo[DATA_W-1:0];
        e.ovf    = 1'b0;
      end
    end
    e.last = (m_step == SLOT_W'(TBL_SIZE - 1));
    pending_entries.push_back(e);
    if (e.last) begin
      m_step  = '0;
      m_power = 16'd1;
    end else begin
      m_step = m_step + 1'b1;
      prod   = 32'(m_power) * 32'(m_omega);
      if (m_modulus == '0) m_power = prod[DATA_W-1:0];
      else m_power = DATA_W'(prod % 32'(m_modulus));
    end
  endtask

  always @(posedge clk) begin : check_entry
    entry_t want;
    entry_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.slot    = out_tdata[SLOT_W-1:0];
      got.twiddle = out_tdata[SLOT_W +: DATA_W];
      got.factor  = out_tdata[SLOT_W+DATA_W +: DATA_W];
      got.ovf     = out_tdata[SLOT_W+2*DATA_W];
      got.last    = out_tlast;
      n_results++;
      if (pending_entries.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = pending_entries.pop_front();
        if (got.slot !== want.slot)
          report_mismatch($sformatf("slot_index got %0d want %0d", got.slot, want.slot));
        if (got.twiddle !== want.twiddle)
          report_mismatch($sformatf("twiddle got %0d want %0d", got.twiddle, want.twiddle));
        if (got.factor !== want.factor)
          report_mismatch($sformatf("barrett_factor got %0d want %0d", got.factor, want.factor));
        if (got.ovf !== want.ovf)
          report_mismatch($sformatf("overflow got %b want %b", got.ovf, want.ovf));
        if (got.last !== want.last)
          report_mismatch($sformatf("last_entry got %b want %b", got.last, want.last));
        if (want.ovf) n_ovf++;
        if (want.last) n_wraps++;
      end
    end
  end

  task automatic send_request(input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(restart);
    do @(posedge clk); while (!in_tready);
    predict_entry(restart);
    n_requests++;
  endtask

  // drop valid and hold off until every pending entry is back and the block is idle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_entries.size() != 0 || !in_tready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_OMEGA:   m_omega   = val;
      REG_MODULUS: m_modulus = val;
      REG_SHIFT:   m_shift   = val[SHIFT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [DATA_W-1:0] omega_v,
                                input logic [DATA_W-1:0] modulus_v,
                                input logic [SHIFT_W-1:0] shift_v);
    logic [DATA_W-SHIFT_W-1:0] junk;
    junk = ($urandom_range(1) == 0) ? '0 : (DATA_W-SHIFT_W)'($urandom);
    write_reg(REG_OMEGA, omega_v);
    write_reg(REG_MODULUS, modulus_v);
    write_reg(REG_SHIFT, {junk, shift_v});
    cfg_we <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  task automatic apply_random_settings(input bit nonzero_mod);
    logic [DATA_W-1:0]  om;
    logic [DATA_W-1:0]  md;
    logic [SHIFT_W-1:0] sh;
    case ($urandom_range(7))
      0:       om = '0;
      1:       om = 16'd1;
      2:       om = 16'hFFFF;
      default: om = DATA_W'($urandom_range(65535));
    endcase
    case ($urandom_range(9))
      0:       md = nonzero_mod ? 16'd65521 : 16'd0;
      1:       md = 16'd1;
      2:       md = 16'd2;
      3:       md = 16'hFFFF;
      4:       md = 16'd65521;
      default: md = DATA_W'($urandom_range(65535, 2));
    endcase
    case ($urandom_range(5))
      0:       sh = '0;
      1:       sh = 5'd16;
      2:       sh = 5'd31;
      default: sh = SHIFT_W'($urandom_range(31));
    endcase
    apply_settings(om, md, sh);
  endtask

  task automatic test_reset_values();
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
  endtask

  task automatic test_corner_settings();
    wait_idle();
    apply_settings(16'hFFFF, 16'hFFFF, 5'd0);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    // wide shift: factor saturates once the power is above one
    wait_idle();
    apply_settings(16'd40000, 16'd65534, 5'd31);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    // zero modulus: plain 16-bit products
    wait_idle();
    apply_settings(16'd3, 16'd0, 5'd16);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    // unit modulus
    wait_idle();
    apply_settings(16'd0, 16'd1, 5'd0);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    wait_idle();
    apply_settings(16'd12345, 16'd65521, 5'd17);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
  endtask

  task automatic test_full_table();
    wait_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    apply_random_settings(1'b1);
    send_request(1'b1);
    repeat (TBL_SIZE + 3) send_request(1'b0);
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int phase = 0; phase < 2; phase++) begin
      wait_idle();
      apply_random_settings(1'b0);
      for (int i = 0; i < n_items / 2; i++) begin
        if ($urandom_range(49) == 0) wait_idle();
        send_request($urandom_range(99) < 3);
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_corner_settings();
    test_full_table();
    test_random_traffic(120, 69, 0);
    test_random_traffic(120, 0, 69);
    test_random_traffic(120, 17, 17);
    test_random_traffic(120, 0, 0);

    wait_idle();
    repeat (80) @(posedge clk);
    if (pending_entries.size() != 0)
      report_mismatch($sformatf("%0d entries never returned", pending_entries.size()));

    $display("%0d requests under %0d register settings, %0d results checked",
             n_requests, n_settings, n_results);
    $display("%0d saturated factors, %0d table wraps seen", n_ovf, n_wraps);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", err_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d entries pending", pending_entries.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
